// ----- hw/rtl/positional_list_insert_remove_assert.svh -----
// Assertion macros used by the checker of the positional list block.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PLI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PLI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

// ----- hw/rtl/pli_pkg.sv -----
// Types and codes shared by the positional list modules.
package pli_pkg;

  // Request codes on the input channel.
  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Operations handed from the front end to the back end. OP_NOTE only
  // reports a status and leaves the list alone.
  typedef enum logic [2:0] {
    OP_NOTE,
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_READ,
    OP_CLEAR
  } op_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  // One classified command.
  typedef struct packed {
    op_t                op;
    status_t            status;
    logic [4:0]         position;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// ----- hw/rtl/positional_list_insert_remove.sv -----
// Positional list of signed 32-bit words, up to DEPTH entries, with append,
// insert at a position, remove at a position, full readout and clear. The
// front end checks each request against its fill count and passes a command
// through a two-entry queue to the back end, which shifts the whole cell row
// in parallel. Append, insert, remove, clear and refused requests each give
// one result. A readout of N stored words gives N results, the last one
// marked; while it runs, the queue takes two more requests and then the
// input stalls. A readout of an empty list gives a single result with status
// empty.
module positional_list_insert_remove #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [3:0]         out_elem_index,
  output logic signed [31:0] out_elem_value,
  output logic [4:0]         out_fill_count,
  output logic               out_last
);
  import pli_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_valid;
  logic front_ready;
  logic queue_valid;
  logic queue_ready;

  // Request classification.
  pli_front #(.DEPTH(DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_value    (in_value),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd),
    .cmd_ready   (front_ready)
  );

  // Decoupling queue.
  pli_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_cmd   (queue_cmd)
  );

  // Cell row and result generation.
  pli_back #(.DEPTH(DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (queue_valid),
    .cmd_ready      (queue_ready),
    .cmd            (queue_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_elem_index (out_elem_index),
    .out_elem_value (out_elem_value),
    .out_fill_count (out_fill_count),
    .out_last       (out_last)
  );

endmodule

// ----- hw/rtl/pli_front.sv -----
// Front end: accepts requests, checks them against the fill count, classifies.
module pli_front #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               cmd_valid,
  output pli_pkg::cmd_t      cmd,
  input  logic               cmd_ready
);
  import pli_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic             empty;
  logic             accept;

  // The front end never holds a request itself; the queue does.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign pos_c = CMP_W'(in_position);
  assign cnt_c = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Classify the request and track the count it leaves behind.
  always_comb begin
    cmd.op       = OP_NOTE;
    cmd.status   = ST_OK;
    cmd.position = in_position;
    cmd.value    = in_value;
    count_nxt    = count_r;
    case (in_req_type)
      REQ_APPEND: begin
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op    = OP_APPEND;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (pos_c > cnt_c) begin
          cmd.status = ST_RANGE;
        end else if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op    = OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.op    = OP_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op = OP_READ;
        end
      end
      REQ_CLEAR: begin
        cmd.op    = OP_CLEAR;
        count_nxt = '0;
      end
      default: begin
        cmd.op = OP_NOTE;
      end
    endcase
  end

  // Fill count as seen by the front end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/pli_queue.sv -----
// Two-entry command queue between the front end and the back end.
module pli_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pli_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pli_pkg::cmd_t rd_cmd
);
  import pli_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/pli_back.sv -----
// Back end: shifts the cell row, walks readouts and holds the result register.
module pli_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pli_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [3:0]         out_elem_index,
  output logic signed [31:0] out_elem_value,
  output logic [4:0]         out_fill_count,
  output logic               out_last
);
  import pli_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [31:0] cells_r [DEPTH];
  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   rd_idx_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               can_load;
  logic               load;
  logic               do_pop;
  logic               last_rd;

  logic               out_valid_r;
  status_t            status_r;
  status_t            status_nxt;
  logic [3:0]         idx_r;
  logic [3:0]         idx_nxt;
  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic [4:0]         fill_r;
  logic [4:0]         fill_nxt;
  logic               last_r;
  logic               last_nxt;

  assign can_load = !out_valid_r || out_ready;
  assign last_rd  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == cnt_r);
  assign do_pop   = cmd_valid && cmd_ready;

  // Sequencer: one command per cycle unless stalled; readouts go word by word.
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    cmd_ready  = 1'b0;
    load       = 1'b0;
    status_nxt = ST_OK;
    idx_nxt    = 4'd0;
    val_nxt    = '0;
    fill_nxt   = 5'(cnt_r);
    last_nxt   = 1'b1;
    case (state_r)
      BK_IDLE: begin
        cmd_ready = can_load;
        if (cmd_valid && can_load) begin
          case (cmd.op)
            OP_READ: begin
              state_nxt  = BK_READ;
              rd_idx_nxt = '0;
            end
            OP_APPEND, OP_INSERT: begin
              load    = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            OP_REMOVE: begin
              load    = 1'b1;
              cnt_nxt = cnt_r - CNT_W'(1);
            end
            OP_CLEAR: begin
              load    = 1'b1;
              cnt_nxt = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
          status_nxt = cmd.status;
          fill_nxt   = 5'(cnt_nxt);
        end
      end
      BK_READ: begin
        if (can_load) begin
          load    = 1'b1;
          idx_nxt = 4'(rd_idx_r);
          val_nxt = cells_r[rd_idx_r];
          last_nxt = last_rd;
          if (last_rd) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_idx_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      val_r    <= val_nxt;
      fill_r   <= fill_nxt;
      last_r   <= last_nxt;
    end
  end

  // Cell row: every cell picks its own word, its neighbor's, or the new value.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      case (cmd.op)
        OP_APPEND: begin
          cells_r[cnt_r[IDX_W-1:0]] <= cmd.value;
        end
        OP_INSERT: begin
          if (cmd.position == 5'd0) begin
            cells_r[0] <= cmd.value;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (i == int'(cmd.position)) begin
              cells_r[i] <= cmd.value;
            end else if (i > int'(cmd.position)) begin
              cells_r[i] <= cells_r[i-1];
            end
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (i >= int'(cmd.position)) begin
              cells_r[i] <= cells_r[i+1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_elem_index = idx_r;
  assign out_elem_value = val_r;
  assign out_fill_count = fill_r;
  assign out_last       = last_r;

endmodule

// ----- hw/rtl/pli_checker.sv -----
// Port-level checker for the positional list, bound to the top level.
`include "positional_list_insert_remove_assert.svh"

module pli_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_req_type,
  input logic [4:0]         in_position,
  input logic signed [31:0] in_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [3:0]         out_elem_index,
  input logic signed [31:0] out_elem_value,
  input logic [4:0]         out_fill_count,
  input logic               out_last
);
  import pli_pkg::*;

  logic [39:0] in_payload;
  logic [43:0] out_payload;
  logic        refused;
  logic        no_elem;

  // Whole payloads of each channel, and the shape of a refusal.
  assign in_payload  = {in_req_type, in_position, in_value};
  assign out_payload = {out_status, out_elem_index, out_elem_value, out_fill_count, out_last};
  assign refused     = out_valid && (out_status != ST_OK);
  assign no_elem     = (out_elem_index == 4'd0) && (out_elem_value == 32'sd0);

  // A waiting request holds its payload.
  `PLI_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_payload))

  // A stalled result holds its payload.
  `PLI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // Refusals are single results with no element payload.
  `PLI_ASSERT_IMP(a_refuse_shape, refused, out_last && no_elem)

  // An empty status always reports an empty list.
  `PLI_ASSERT_IMP(a_empty_count, out_valid && (out_status == ST_EMPTY), out_fill_count == 5'd0)

  // The reported fill never passes the capacity.
  `PLI_ASSERT_IMP(a_fill_bound, out_valid, int'(out_fill_count) <= int'(DEPTH))

endmodule

bind positional_list_insert_remove pli_checker #(.DEPTH(DEPTH)) u_pli_checker (.*);
